>>> rtl/dbcc_pkg.sv
// ----------------------------------------------------------------------------
// dbcc_pkg: shared types and constants
// Field widths, format codes and the front-to-back command word.
// ----------------------------------------------------------------------------
`default_nettype none
package dbcc_pkg;
	localparam int WordW  = 32;
	localparam int CodeW  = 35;
	localparam int BitsW  = 6;
	localparam int FmtW   = 3;
	localparam int DictN  = 8;
	localparam int IdxW   = 3;
	localparam int CfgIdxW = 3;

	typedef enum logic [FmtW-1:0] {
		FMT_RUN   = 3'd0,
		FMT_BMASK = 3'd1,
		FMT_ONE   = 3'd2,
		FMT_ADJ   = 3'd3,
		FMT_TWO   = 3'd4,
		FMT_EXACT = 3'd5,
		FMT_RAW   = 3'd6
	} fmt_t;

	// One classified input word: optional leading run code, optional word
	// to encode, optional trailing run code.
	typedef struct packed {
		logic             pre_run;
		logic [1:0]       pre_cnt;
		logic             enc;
		logic [WordW-1:0] word;
		logic             post_run;
		logic [1:0]       post_cnt;
	} cmd_t;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [BitsW-1:0] code_bits;
		logic [FmtW-1:0]  format_used;
		logic             last_of_item;
	} res_t;
endpackage
`default_nettype wire

>>> rtl/dbcc_if.sv
// ----------------------------------------------------------------------------
// dbcc_in_if / dbcc_out_if: valid/ready channels
// Input word channel and result code channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface dbcc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic        end_of_stream;
	modport source (output valid, output instr_word, output end_of_stream, input ready);
	modport sink (input valid, input instr_word, input end_of_stream, output ready);
endinterface

interface dbcc_out_if;
	logic        valid;
	logic        ready;
	logic [34:0] code;
	logic [5:0]  code_bits;
	logic [2:0]  format_used;
	logic        last_of_item;
	modport source (output valid, output code, output code_bits, output format_used,
		output last_of_item, input ready);
	modport sink (input valid, input code, input code_bits, input format_used,
		input last_of_item, output ready);
endinterface
`default_nettype wire

>>> rtl/dictionary_bitmask_code_compressor_core.sv
// ----------------------------------------------------------------------------
// dictionary_bitmask_code_compressor_core: bitmask dictionary code compressor
// Streams 32-bit instruction words into variable-length codes.
// ----------------------------------------------------------------------------
// One input word per cycle while the command queue has room. A word yields zero,
// one or two codes; a word that produces two codes holds the back end
// for both, absorbed by a two-entry command queue between front
// (run tracking) and back (eight-lane xor/popcount matcher, sequencer).
// The first code of a word is valid on the output after passing through the
// command queue and the registered result. Dictionary words are written through
// the cfg port while the block is idle; the user must ensure this, the block does not enforce it.
`default_nettype none
module dictionary_bitmask_code_compressor_core (
	input  wire        clk,
	input  wire        arst_n,
	dbcc_in_if.sink    in_ch,
	dbcc_out_if.source out_ch,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_idx,
	input  wire [31:0] cfg_data
);
	import dbcc_pkg::*;

	logic [WordW-1:0] dict_q [DictN];
	cmd_t             cmd_new, q_mem_q [2], q_head;
	logic             q_rd_q, q_wr_q;
	logic [1:0]       q_cnt_q;
	logic             in_fire, pop, q_valid;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DictN; i++) dict_q[i] <= '0;
		end else if (cfg_we) begin
			dict_q[cfg_idx] <= cfg_data;
		end
	end

	assign in_ch.ready = (q_cnt_q != 2'd2);
	assign in_fire = in_ch.valid && in_ch.ready;

	dbcc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.instr_word(in_ch.instr_word), .end_of_stream(in_ch.end_of_stream),
		.cmd(cmd_new)
	);

	// Two-entry command queue.
	assign q_valid = (q_cnt_q != 2'd0);
	assign q_head  = q_mem_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_rd_q <= 1'b0; q_wr_q <= 1'b0; q_cnt_q <= '0;
		end else begin
			if (in_fire) q_wr_q <= ~q_wr_q;
			if (pop) q_rd_q <= ~q_rd_q;
			q_cnt_q <= q_cnt_q + {1'b0, in_fire} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) q_mem_q[q_wr_q] <= cmd_new;
	end

	dbcc_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid), .cmd_pop(pop), .cmd(q_head),
		.dict(dict_q), .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
	);

	assign out_ch.code         = res.code;
	assign out_ch.code_bits    = res.code_bits;
	assign out_ch.format_used  = res.format_used;
	assign out_ch.last_of_item = res.last_of_item;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= 2'd2) else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.code_bits >= 6'd5) else $error("bad code length");
endmodule
`default_nettype wire

>>> rtl/dbcc_front.sv
// ----------------------------------------------------------------------------
// dbcc_front: run tracking and classification
// Holds previous word and repeat count, turns each word into a command.
// ----------------------------------------------------------------------------
`default_nettype none
module dbcc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_fire,
	input  wire [31:0]           instr_word,
	input  wire                  end_of_stream,
	output dbcc_pkg::cmd_t       cmd
);
	import dbcc_pkg::*;

	logic [WordW-1:0] prev_word_q;
	logic             prev_valid_q;
	logic [1:0]       reps_q;     // pending repeats 0..3
	logic             rep;
	logic [2:0]       reps_inc;
	logic [1:0]       reps_nxt;

	assign rep      = prev_valid_q && (instr_word == prev_word_q);
	assign reps_inc = {1'b0, reps_q} + 3'd1;

	always_comb begin
		cmd = '0;
		cmd.word = instr_word;
		reps_nxt = reps_q;
		if (rep) begin
			if (reps_inc[2]) begin
				cmd.pre_run = 1'b1;
				cmd.pre_cnt = 2'd3;
				reps_nxt = 2'd0;
			end else begin
				reps_nxt = reps_inc[1:0];
			end
		end else begin
			cmd.enc = 1'b1;
			if (reps_q != 2'd0) begin
				cmd.pre_run = 1'b1;
				cmd.pre_cnt = reps_q - 2'd1;
			end
			reps_nxt = 2'd0;
		end
		if (end_of_stream && reps_nxt != 2'd0) begin
			cmd.post_run = 1'b1;
			cmd.post_cnt = reps_nxt - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			reps_q <= '0;
			prev_word_q <= '0;
		end else if (in_fire) begin
			if (!rep) prev_word_q <= instr_word;
			prev_valid_q <= end_of_stream ? 1'b0 : 1'b1;
			reps_q <= end_of_stream ? 2'd0 : reps_nxt;
		end
	end
endmodule
`default_nettype wire

>>> rtl/dbcc_back.sv
// ----------------------------------------------------------------------------
// dbcc_back: dictionary encoder and code sequencer
// Pops commands, emits up to two codes each, registered output.
// ----------------------------------------------------------------------------
`default_nettype none
module dbcc_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cmd_valid,
	output logic                       cmd_pop,
	input  wire dbcc_pkg::cmd_t        cmd,
	input  wire [31:0]                 dict [8],
	output logic                       res_valid,
	input  wire                        res_ready,
	output dbcc_pkg::res_t             res
);
	import dbcc_pkg::*;

	// Phase: 0 leading run, 1 word, 2 trailing run.
	logic [1:0] phase_q;
	logic       has [3];
	logic [1:0] cur;
	logic       found, more;
	res_t       r_enc, r_cur;

	// ---- encoder (eight parallel xor/popcount lanes) ----
	always_comb begin
		logic [31:0] d;
		logic [5:0]  n;
		logic [4:0]  f, l, s;
		logic        ex_f, one_f, adj_f, bm_f, two_f;
		logic [2:0]  ex_i, one_i, adj_i, bm_i, two_i;
		logic [4:0]  one_p, adj_p, bm_p, two_p, two_q;
		logic [3:0]  bm_m;
		logic [31:0] sh;
		ex_f = 0; one_f = 0; adj_f = 0; bm_f = 0; two_f = 0;
		ex_i = 0; one_i = 0; adj_i = 0; bm_i = 0; two_i = 0;
		one_p = 0; adj_p = 0; bm_p = 0; two_p = 0; two_q = 0; bm_m = 0;
		for (int i = DictN - 1; i >= 0; i--) begin
			d = cmd.word ^ dict[i];
			n = 6'($countones(d));
			f = 5'd0; l = 5'd0;
			for (int b = 0; b < 32; b++) if (d[b]) f = 5'(31 - b);
			for (int b = 31; b >= 0; b--) if (d[b]) l = 5'(31 - b);
			s = (f > 5'd28) ? 5'd28 : f;
			sh = d >> (5'd28 - s);
			if (n == 0) begin ex_f = 1; ex_i = 3'(i); end
			if (n == 1) begin one_f = 1; one_i = 3'(i); one_p = f; end
			if (n == 2 && l == f + 5'd1) begin adj_f = 1; adj_i = 3'(i); adj_p = f; end
			if (n == 2 && l != f + 5'd1) begin
				two_f = 1; two_i = 3'(i); two_p = f; two_q = l;
			end
			if (n != 0 && n <= 4 && (l - f) < 5'd4) begin
				bm_f = 1; bm_i = 3'(i); bm_p = s; bm_m = sh[3:0];
			end
		end
		r_enc = '0;
		if (ex_f) begin
			r_enc.code = 35'({3'b101, ex_i}); r_enc.code_bits = 6'd6;
			r_enc.format_used = FMT_EXACT;
		end else if (one_f) begin
			r_enc.code = 35'({3'b010, one_p, one_i}); r_enc.code_bits = 6'd11;
			r_enc.format_used = FMT_ONE;
		end else if (adj_f) begin
			r_enc.code = 35'({3'b011, adj_p, adj_i}); r_enc.code_bits = 6'd11;
			r_enc.format_used = FMT_ADJ;
		end else if (bm_f) begin
			r_enc.code = 35'({3'b001, bm_p, bm_m, bm_i}); r_enc.code_bits = 6'd15;
			r_enc.format_used = FMT_BMASK;
		end else if (two_f) begin
			r_enc.code = 35'({3'b100, two_p, two_q, two_i}); r_enc.code_bits = 6'd16;
			r_enc.format_used = FMT_TWO;
		end else begin
			r_enc.code = {3'b110, cmd.word}; r_enc.code_bits = 6'd35;
			r_enc.format_used = FMT_RAW;
		end
	end

	// ---- sequencer ----
	assign has[0] = cmd.pre_run;
	assign has[1] = cmd.enc;
	assign has[2] = cmd.post_run;

	logic out_free, step;
	assign out_free = !res_valid || res_ready;

	always_comb begin
		cur = 2'd0; found = 0;
		for (int p = 2; p >= 0; p--)
			if (has[p] && 2'(p) >= phase_q) begin cur = 2'(p); found = 1; end
		more = 0;
		for (int p = 0; p < 3; p++) if (has[p] && 2'(p) > cur) more = 1;
		r_cur = '0;
		case (cur)
			2'd0: begin
				r_cur.code = 35'(cmd.pre_cnt); r_cur.code_bits = 6'd5;
				r_cur.format_used = FMT_RUN;
			end
			2'd1: r_cur = r_enc;
			default: begin
				r_cur.code = 35'(cmd.post_cnt); r_cur.code_bits = 6'd5;
				r_cur.format_used = FMT_RUN;
			end
		endcase
		r_cur.last_of_item = !more;
	end

	assign step    = cmd_valid && out_free;
	// Commands with nothing to emit drop at once.
	assign cmd_pop = cmd_valid && (!found || (out_free && !more));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			res_valid <= 1'b0;
		end else begin
			if (out_free) res_valid <= step && found;
			if (cmd_pop) phase_q <= 2'd0;
			else if (step && found) phase_q <= cur + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && found) res <= r_cur;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res)) else $error("held result");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("phase range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> phase_q == 2'd0) else $error("phase reset");
endmodule
`default_nettype wire
